// File: rtl/binary_to_bcd_converter_defines.svh
// Assertion macros for the binary to BCD converter.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef BINARY_TO_BCD_CONVERTER_DEFINES_SVH
`define BINARY_TO_BCD_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
`define B2BCD_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("b2bcd: assertion failed");
`define B2BCD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("b2bcd: assertion failed");
`else
`define B2BCD_ASSERT_RST(label, clk, rst_n, prop)
`define B2BCD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: rtl/b2bcd_pkg.sv
// Shared constants and types of the binary to BCD converter.
// No dependencies; every other source file of the block except the defines header imports it.
`timescale 1ns / 1ps

package b2bcd_pkg;

    localparam int DIGIT_COUNT = 16;
    localparam int INPUT_BYTES = 8;

    localparam int VALUE_W    = 64;
    localparam int COUNT_W    = 4;
    localparam int OUT_W      = 64;
    localparam int OUT_DIGITS = OUT_W / 4;

    // Only the digits that fit in the output are carried through the pipeline.
    localparam int KEPT_DIGITS = (DIGIT_COUNT < OUT_DIGITS) ? DIGIT_COUNT : OUT_DIGITS;
    localparam int BCD_W       = 4 * KEPT_DIGITS;
    localparam int DD_BITS     = 8 * INPUT_BYTES;

    // One shift-and-add-3 stage handles one input byte.
    localparam int STEPS_PER_STAGE = 8;
    localparam int STAGE_COUNT     = INPUT_BYTES;

    localparam logic [3:0] DABBLE_LIMIT  = 4'd5;
    localparam logic [3:0] DABBLE_ADJUST = 4'd3;
    localparam logic [3:0] MAX_DIGIT     = 4'd9;

    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [DD_BITS-1:0] bin;
    } t_dd_word;

endpackage

// File: rtl/b2bcd_if.sv
// Valid/ready channel interfaces of the binary to BCD converter.
// Depends on b2bcd_pkg for the payload widths.
`timescale 1ns / 1ps

interface b2bcd_in_if;
    import b2bcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] byte_count;

    modport source (output valid, output value, output byte_count, input ready);
    modport sink   (input valid, input value, input byte_count, output ready);
endinterface

interface b2bcd_out_if;
    import b2bcd_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] bcd_digits;

    modport source (output valid, output bcd_digits, input ready);
    modport sink   (input valid, input bcd_digits, output ready);
endinterface

// File: rtl/b2bcd_mask_stage.sv
// First pipeline stage: keeps the low byte_count bytes of the input value.
// Depends on b2bcd_pkg.
`timescale 1ns / 1ps

module b2bcd_mask_stage (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [b2bcd_pkg::VALUE_W-1:0] i_value,
    input  logic [b2bcd_pkg::COUNT_W-1:0] i_byte_count,
    output logic                         o_valid,
    input  logic                         i_ready,
    output b2bcd_pkg::t_dd_word          o_word
);
    import b2bcd_pkg::*;

    logic     r_valid;
    t_dd_word r_word;
    t_dd_word n_word;

    // A count above the byte limit keeps every byte, which is the saturation.
    always_comb begin
        n_word     = '0;
        for (int b = 0; b < INPUT_BYTES; b++) begin
            if (COUNT_W'(b) < i_byte_count) begin
                n_word.bin[8*b +: 8] = i_value[8*b +: 8];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// File: rtl/b2bcd_dabble_stage.sv
// One pipeline stage of the shift-and-add-3 conversion: eight bit steps.
// Depends on b2bcd_pkg.
`timescale 1ns / 1ps

module b2bcd_dabble_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  b2bcd_pkg::t_dd_word i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output b2bcd_pkg::t_dd_word o_word
);
    import b2bcd_pkg::*;

    logic     r_valid;
    t_dd_word r_word;
    t_dd_word n_word;

    // Each step corrects every digit of five or more, then shifts the next
    // binary bit into the units digit. Digits above the kept ones fall off
    // the top, which does not disturb the lower digits.
    always_comb begin
        n_word = i_word;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            for (int d = 0; d < KEPT_DIGITS; d++) begin
                if (n_word.bcd[4*d +: 4] >= DABBLE_LIMIT) begin
                    n_word.bcd[4*d +: 4] = n_word.bcd[4*d +: 4] + DABBLE_ADJUST;
                end
            end
            n_word = {n_word[BCD_W+DD_BITS-2:0], 1'b0};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// File: rtl/binary_to_bcd_converter.sv
// Binary to packed BCD converter, pipeline top level.
// Depends on b2bcd_pkg, b2bcd_if, b2bcd_mask_stage, b2bcd_dabble_stage and
// binary_to_bcd_converter_defines.svh.
//
// Usage: an input transfer on i_in carries a 64-bit value (least significant
// byte first) and a byte count; only the low byte_count bytes are converted,
// and counts above eight keep all bytes. Each input transfer yields exactly
// one output transfer on o_out with sixteen packed BCD digits, units digit in
// bits 3..0; higher decimal digits are dropped.
// Structure: one masking stage plus one shift-and-add-3 stage per input byte,
// nine register stages in all. Throughput is one transfer per cycle while
// o_out.ready stays high; each stage handles eight bits of the conversion.
// When o_out.ready is low, results stay in the stages and bubbles are
// squeezed out; i_in.ready drops only once every stage holds an item.
// Reset (i_rst_n low, synchronous) empties the pipeline; nothing else is kept.
`timescale 1ns / 1ps
`include "binary_to_bcd_converter_defines.svh"

module binary_to_bcd_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b2bcd_in_if.sink    i_in,
    b2bcd_out_if.source o_out
);
    import b2bcd_pkg::*;

    logic     w_valid [0:STAGE_COUNT];
    logic     w_ready [0:STAGE_COUNT];
    t_dd_word w_word  [0:STAGE_COUNT];
    logic     w_all_valid;
    logic     w_bcd_legal;

    b2bcd_mask_stage u_mask (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_value      (i_in.value),
        .i_byte_count (i_in.byte_count),
        .o_valid      (w_valid[0]),
        .i_ready      (w_ready[0]),
        .o_word       (w_word[0])
    );

    for (genvar k = 0; k < STAGE_COUNT; k++) begin : g_stage
        b2bcd_dabble_stage u_dabble (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_word  (w_word[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_word  (w_word[k+1])
        );
    end

    assign w_ready[STAGE_COUNT] = o_out.ready;
    assign o_out.valid          = w_valid[STAGE_COUNT];
    assign o_out.bcd_digits     = OUT_W'(w_word[STAGE_COUNT].bcd);

    always_comb begin
        w_all_valid = 1'b1;
        for (int k = 0; k <= STAGE_COUNT; k++) begin
            w_all_valid = w_all_valid && w_valid[k];
        end
    end

    always_comb begin
        w_bcd_legal = 1'b1;
        for (int d = 0; d < OUT_DIGITS; d++) begin
            w_bcd_legal = w_bcd_legal && (o_out.bcd_digits[4*d +: 4] <= MAX_DIGIT);
        end
    end

    // A full pipeline facing a stalled receiver must refuse new input.
    `B2BCD_ASSERT_RST(a_full_stall, i_clk, i_rst_n, w_all_valid && !o_out.ready |-> !i_in.ready)
    // Every nibble of a delivered result is a decimal digit.
    `B2BCD_ASSERT_RST(a_bcd_legal, i_clk, i_rst_n, o_out.valid |-> w_bcd_legal)
    // Reset empties the pipeline by the next edge.
    `B2BCD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out.valid)

endmodule

// File: bench/testbench.sv
// Testbench for the binary to packed BCD converter: directed corner values, random
// values, output back-pressure and drain pauses, each result checked against a predictor.
// Depends on b2bcd_pkg, the b2bcd_if channel interfaces and the binary_to_bcd_converter RTL.
`timescale 1ns / 1ps

module testbench;
    import b2bcd_pkg::*;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} t_rx_mode;

    localparam int PIPE_DEPTH      = 9;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT      = 3000;
    localparam int REPORT_LIMIT    = 40;
    localparam int PHASE_ITEMS     = 135;
    localparam int RANDOM_PHASES   = 7;

    logic i_clk = 1'b0;
    logic i_rst_n;

    b2bcd_in_if  in_ch ();
    b2bcd_out_if out_ch ();

    binary_to_bcd_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [OUT_W-1:0] expected_bcd_q[$];
    int               mismatch_count;
    int               tx_gap_max;
    int               tx_burst_left;
    t_rx_mode         rx_mode;
    logic             rx_hold_request;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Decimal conversion of the masked value; digits past the output width are lost.
    function automatic logic [OUT_W-1:0] predict_bcd(logic [VALUE_W-1:0] value,
                                                      logic [COUNT_W-1:0] byte_count);
        bit [VALUE_W-1:0] number;
        bit [VALUE_W-1:0] digit;
        logic [OUT_W-1:0] packed_digits;
        int               used_bytes;
        number        = value;
        packed_digits = '0;
        used_bytes    = (byte_count > INPUT_BYTES) ? INPUT_BYTES : int'(byte_count);
        if (used_bytes < 8) begin
            number = number & ((64'h1 << (8 * used_bytes)) - 64'h1);
        end
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            digit  = number % 64'd10;
            number = number / 64'd10;
            if (i < OUT_DIGITS) begin
                packed_digits[4*i +: 4] = digit[3:0];
            end
        end
        return packed_digits;
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] want);
        if (mismatch_count < REPORT_LIMIT) begin
            $display("%0t: %s: bcd_digits got %h, expected %h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    // Prediction is made when the input transfer is seen.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            expected_bcd_q.insert(expected_bcd_q.size(),
                                  predict_bcd(in_ch.value, in_ch.byte_count));
        end
    end

    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_bcd_q.size() == 0) begin
                report_mismatch("result with no pending input", out_ch.bcd_digits, '0);
            end else begin
                want = expected_bcd_q.pop_front();
                if (out_ch.bcd_digits !== want) begin
                    report_mismatch("wrong result", out_ch.bcd_digits, want);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        int idle_cycles;
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Result side: free-running, random, or a rotating stall pattern, plus a long hold-off
    // on request.
    initial begin
        int          hold_left;
        int          pattern_age;
        logic [15:0] pattern;
        hold_left    = 0;
        pattern_age  = 0;
        pattern      = 16'hFFFF;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_request) begin
                hold_left       = RX_HOLD_CYCLES;
                rx_hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready = 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: begin
                        out_ch.ready = 1'b1;
                    end
                    RX_RANDOM: begin
                        out_ch.ready = ($urandom_range(0, 2) != 0);
                    end
                    default: begin
                        out_ch.ready = pattern[0];
                        pattern      = {pattern[0], pattern[15:1]};
                        pattern_age++;
                        if (pattern_age == 64) begin
                            pattern_age = 0;
                            pattern     = 16'($urandom) | 16'h0001;
                        end
                    end
                endcase
            end
        end
    end

    task automatic send_value(input logic [VALUE_W-1:0] value,
                              input logic [COUNT_W-1:0] byte_count);
        int gap;
        if (tx_burst_left == 0) begin
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            repeat (gap) begin
                @(negedge i_clk);
                in_ch.valid = 1'b0;
            end
            tx_burst_left = $urandom_range(1, 24);
        end
        tx_burst_left--;
        @(negedge i_clk);
        in_ch.valid      = 1'b1;
        in_ch.value      = value;
        in_ch.byte_count = byte_count;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Valid must drop before any pause, or the last item would be taken twice.
    task automatic release_sender();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] power;
        value = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: value = value >> $urandom_range(0, 63);
            1: begin
                power = 64'd1;
                repeat ($urandom_range(0, 19)) power = power * 64'd10;
                value = power + 64'($urandom_range(0, 2)) - 64'd1;
            end
            2: value = $urandom_range(0, 1) ? '1 : '0;
            default: ;
        endcase
        return value;
    endfunction

    function automatic logic [COUNT_W-1:0] random_count();
        if ($urandom_range(0, 9) < 8) begin
            return COUNT_W'($urandom_range(1, INPUT_BYTES));
        end
        return COUNT_W'($urandom_range(0, 15));
    endfunction

    task automatic test_directed();
        tx_gap_max = 0;
        rx_mode    = RX_ALWAYS;
        send_value('0, 4'd0);
        // A count of zero ignores every bit of the value.
        send_value('1, 4'd0);
        for (int n = 1; n <= 15; n++) begin
            // Counts above eight saturate and keep all bytes.
            send_value('1, COUNT_W'(n));
        end
        send_value(64'd9999999999999999, 4'd8);
        // Seventeen digits: the leading one falls off the output.
        send_value(64'd10000000000000000, 4'd8);
        send_value(64'd12345678901234567890, 4'd8);
        send_value(64'h0000_0000_0000_0100, 4'd1);
        send_value(64'd10, 4'd1);
        send_value(64'd99, 4'd1);
        send_value(64'd100, 4'd1);
    endtask

    task automatic test_random();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                tx_gap_max = 0;
                rx_mode    = RX_ALWAYS;
            end else begin
                case ($urandom_range(0, 3))
                    0: tx_gap_max = 0;
                    1: tx_gap_max = 3;
                    2: tx_gap_max = 12;
                    default: tx_gap_max = 40;
                endcase
                rx_mode = t_rx_mode'($urandom_range(0, 2));
            end
            repeat (PHASE_ITEMS) send_value(random_value(), random_count());
        end
    endtask

    // The result side stops for a long stretch while items keep coming, so the
    // pipeline fills and the input side must stall.
    task automatic test_backpressure();
        tx_gap_max      = 0;
        rx_mode         = RX_RANDOM;
        rx_hold_request = 1'b1;
        repeat (60) send_value(random_value(), random_count());
    endtask

    task automatic test_drain();
        tx_gap_max = 5;
        rx_mode    = RX_PATTERN;
        release_sender();
        while (expected_bcd_q.size() != 0) @(posedge i_clk);
        repeat (20) send_value(random_value(), random_count());
    endtask

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.value      = '0;
        in_ch.byte_count = '0;
        mismatch_count   = 0;
        tx_gap_max       = 0;
        tx_burst_left    = 0;
        rx_mode          = RX_ALWAYS;
        rx_hold_request  = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random();
        test_backpressure();
        test_drain();

        release_sender();
        rx_mode = RX_RANDOM;
        while (expected_bcd_q.size() != 0) @(posedge i_clk);
        repeat (3 * PIPE_DEPTH) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: binary_to_bcd_converter.f
+incdir+rtl
rtl/b2bcd_pkg.sv
rtl/b2bcd_if.sv
rtl/b2bcd_mask_stage.sv
rtl/b2bcd_dabble_stage.sv
rtl/binary_to_bcd_converter.sv
bench/testbench.sv
